// File: hw/rtl/rfc_pkg.sv
// Package for the response frame checker: shared constants, types and the CRC step.
// Used by rfc_frame_eval and response_frame_checker_top; depends on nothing else.

package rfc_pkg;

	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;
	localparam logic [8:0]  COUNT_MAX     = 9'd511;
	localparam logic [7:0]  MAX_LEN_RESET = 8'd64;
	localparam int          OUT_BITS      = 56;

	typedef struct packed {
		logic [8:0]      count;
		logic [15:0]     crc;
		logic [15:0]     crc_prev;
		logic [4:0][7:0] hdr;
		logic [15:0]     snap;
		logic [15:0]     rx_crc;
		logic [7:0]      prev_byte;
	} frame_state_t;

	localparam frame_state_t FRAME_CLEAR = '{
		count:     9'd0,
		crc:       CRC_INIT,
		crc_prev:  CRC_INIT,
		hdr:       '0,
		snap:      16'd0,
		rx_crc:    16'd0,
		prev_byte: 8'd0
	};

	typedef struct packed {
		logic        accepted;
		logic        new_format;
		logic [7:0]  response_type;
		logic [7:0]  response_code;
		logic [7:0]  response_status;
		logic [7:0]  payload_length;
		logic [15:0] frame_crc;
	} verdict_t;

	function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: hw/rtl/rfc_frame_eval.sv
// Per-byte frame evaluation: next frame state and the end-of-frame verdict.
// Depends on rfc_pkg.

module rfc_frame_eval
	import rfc_pkg::*;
(
	input  frame_state_t st,
	input  logic [7:0]   frame_byte,
	input  logic [7:0]   max_len,
	output frame_state_t st_next,
	output verdict_t     verdict
);

	logic [8:0]  at;
	logic [9:0]  n_ext;
	logic [7:0]  dl;
	logic [7:0]  len;
	logic [7:0]  dl_new;
	logic [15:0] rx_new;
	logic        legacy_fits;
	logic        new_ok;

	always_comb begin
		st_next = st;
		for (int i = 0; i < 5; i++) begin
			if (st.count == 9'(i)) begin
				st_next.hdr[i] = frame_byte;
			end
		end
		at = 9'd4 + {1'b0, st.hdr[3]};
		if (st.count >= 9'd4) begin
			if (st.count == at) begin
				st_next.snap   = st.crc;
				st_next.rx_crc = {8'd0, frame_byte};
			end else if (st.count == at + 9'd1) begin
				st_next.rx_crc = st.rx_crc | {frame_byte, 8'd0};
			end
		end
		st_next.crc_prev  = st.crc;
		st_next.crc       = crc_step(st.crc, frame_byte);
		st_next.prev_byte = frame_byte;
		if (st.count < COUNT_MAX) begin
			st_next.count = st.count + 9'd1;
		end
	end

	always_comb begin
		n_ext  = {1'b0, st_next.count};
		dl     = st_next.hdr[3];
		len    = st_next.hdr[1];
		dl_new = st_next.hdr[4];
		rx_new = {frame_byte, st.prev_byte};
		legacy_fits = (n_ext >= 10'd6) && (n_ext >= 10'd6 + {2'b0, dl});
		new_ok = (n_ext >= 10'd7) && (n_ext == {2'b0, len} + 10'd4) && (len >= 8'd3)
			&& ({1'b0, len} == {1'b0, dl_new} + 9'd3) && (dl_new <= max_len)
			&& (st.crc_prev == rx_new);
		verdict = '0;
		if (legacy_fits && (dl > max_len)) begin
			verdict = '0;
		end else if (legacy_fits && (st_next.snap == st_next.rx_crc)) begin
			verdict.accepted        = 1'b1;
			verdict.new_format      = 1'b0;
			verdict.response_type   = st_next.hdr[0];
			verdict.response_code   = st_next.hdr[1];
			verdict.response_status = st_next.hdr[2];
			verdict.payload_length  = dl;
			verdict.frame_crc       = st_next.rx_crc;
		end else if (new_ok) begin
			verdict.accepted        = 1'b1;
			verdict.new_format      = 1'b1;
			verdict.response_type   = st_next.hdr[0];
			verdict.response_code   = st_next.hdr[2];
			verdict.response_status = st_next.hdr[3];
			verdict.payload_length  = dl_new;
			verdict.frame_crc       = rx_new;
		end
	end

endmodule

// File: hw/rtl/response_frame_checker_top.sv
// Top level of the response frame checker: frame state, config register, result register.
// Depends on rfc_pkg and rfc_frame_eval.

// The checker takes one frame byte per cycle while s_tready is high and keeps a running
// reflected CRC-16 (polynomial 0xA001, initial value 0xFFFF) along with the header bytes it
// needs. On the byte marked tlast it gives one verdict item, registered and valid in the
// cycle after that byte is accepted; other bytes give no output item. The legacy layout is
// tried first, then the layout with a length byte. The per-byte CRC step and the length and
// CRC compares sit between the frame state and the result register. Input is taken whenever
// the result register is empty or being drained. The max data length register may only be
// written while no frame is in progress.

module response_frame_checker_top
	import rfc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,  // [7:0] frame_byte
	input  logic                s_tlast,  // end_of_frame
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_BITS-1:0] m_tdata,  // [0] accepted, [1] new_format, [9:2] response_type,
	                                      // [17:10] response_code, [25:18] response_status,
	                                      // [33:26] payload_length, [49:34] frame_crc, rest 0
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);

	frame_state_t state_q;
	frame_state_t state_next;
	verdict_t     verdict;
	verdict_t     result_q;
	logic         result_valid_q;
	logic [7:0]   max_len_q;
	logic         in_fire;

	assign s_tready  = !result_valid_q || m_tready;
	assign in_fire   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	rfc_frame_eval u_eval (
		.st         (state_q),
		.frame_byte (s_tdata),
		.max_len    (max_len_q),
		.st_next    (state_next),
		.verdict    (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FRAME_CLEAR;
		end else if (in_fire) begin
			state_q <= s_tlast ? FRAME_CLEAR : state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (in_fire && s_tlast) begin
			result_valid_q <= 1'b1;
		end else if (m_tready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && s_tlast) begin
			result_q <= verdict;
		end
	end

	assign m_tvalid = result_valid_q;
	assign m_tdata  = {6'd0, result_q.frame_crc, result_q.payload_length,
		result_q.response_status, result_q.response_code, result_q.response_type,
		result_q.new_format, result_q.accepted};

endmodule
